### hdl/chs_pkg.sv
// Package with shared types, field widths and the microcode program of the hash set.
`timescale 1ns / 1ps

package chs_pkg;

  // Field widths of the request and response transactions.
  localparam int KIND_W = 2;
  localparam int KEY_W  = 31;
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 3;
  localparam int STEP_W = 4;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_INS_NUM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INS_TEXT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SRC_NUM  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SRC_TEXT = 2'd3;

  // Longest text key that is packed.
  localparam logic [LEN_W-1:0] MAX_TEXT_LEN = 3'd4;

  // Program addresses.
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK  = 4'd1;
  localparam logic [STEP_W-1:0] STEP_PACK   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MOD    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SCAN0  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SCAN   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_INSERT = 4'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_HOLD   = 4'd8;

  // Datapath operation selected by a control word.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_PACK,
    OP_MOD,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_INSERT,
    OP_EMIT
  } op_e;

  // Jump condition selected by a control word.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_SKIP_PACK,
    C_PACK_MORE,
    C_MOD_MORE,
    C_SCAN_MORE,
    C_OUT_FREE
  } cond_e;

  // One control word of the program.
  typedef struct packed {
    logic              in_ready;
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Datapath flags tested by the jump conditions.
  typedef struct packed {
    logic in_valid;
    logic skip_pack;
    logic pack_more;
    logic mod_more;
    logic scan_more;
    logic out_free;
  } status_t;

  // Microcode ROM: one control word per program step.
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{in_ready: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE:   w = '{in_ready: 1'b1, op: OP_LOAD, cond: C_NO_INPUT, target: STEP_IDLE};
      STEP_CHECK:  w = '{in_ready: 1'b0, op: OP_NONE, cond: C_SKIP_PACK, target: STEP_MOD};
      STEP_PACK:   w = '{in_ready: 1'b0, op: OP_PACK, cond: C_PACK_MORE, target: STEP_PACK};
      STEP_MOD:    w = '{in_ready: 1'b0, op: OP_MOD, cond: C_MOD_MORE, target: STEP_MOD};
      STEP_SCAN0:  w = '{in_ready: 1'b0, op: OP_SCAN_INIT, cond: C_NEVER, target: STEP_IDLE};
      STEP_SCAN:   w = '{in_ready: 1'b0, op: OP_SCAN, cond: C_SCAN_MORE, target: STEP_SCAN};
      STEP_INSERT: w = '{in_ready: 1'b0, op: OP_INSERT, cond: C_NEVER, target: STEP_IDLE};
      STEP_EMIT:   w = '{in_ready: 1'b0, op: OP_EMIT, cond: C_OUT_FREE, target: STEP_IDLE};
      STEP_HOLD:   w = '{in_ready: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: STEP_EMIT};
      default:     w = '{in_ready: 1'b0, op: OP_NONE, cond: C_ALWAYS, target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

### hdl/chs_if.sv
// Request and response channel interfaces of the hash set.
`timescale 1ns / 1ps

interface chs_req_if;
  logic                          valid;
  logic                          ready;
  logic [chs_pkg::KIND_W-1:0]    kind;
  logic [chs_pkg::KEY_W-1:0]     number;
  logic [chs_pkg::CHAR_W-1:0]    char_first;
  logic [chs_pkg::CHAR_W-1:0]    char_second;
  logic [chs_pkg::CHAR_W-1:0]    char_third;
  logic [chs_pkg::CHAR_W-1:0]    char_fourth;
  logic [chs_pkg::LEN_W-1:0]     text_length;

  modport source (
    output valid, kind, number, char_first, char_second, char_third, char_fourth,
           text_length,
    input  ready
  );
  modport sink (
    input  valid, kind, number, char_first, char_second, char_third, char_fourth,
           text_length,
    output ready
  );
endinterface

interface chs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic                      stored;
  logic                      chain_full;
  logic [chs_pkg::KEY_W-1:0] packed_key;

  modport source (
    output valid, found, stored, chain_full, packed_key,
    input  ready
  );
  modport sink (
    input  valid, found, stored, chain_full, packed_key,
    output ready
  );
endinterface

### hdl/chs_sequencer.sv
// Microcode sequencer: step counter, control ROM fetch and conditional jumps.
`timescale 1ns / 1ps

module chs_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chs_pkg::status_t status_i,
  output chs_pkg::ctrl_t   ctrl_o
);

  logic [chs_pkg::STEP_W-1:0] pc_q, pc_d;
  chs_pkg::ctrl_t             word;
  logic                       take;

  // Fetch the control word of the current step.
  assign word   = chs_pkg::rom_word(pc_q);
  assign ctrl_o = word;

  // Evaluate the jump condition and pick the next step.
  always_comb begin
    unique case (word.cond)
      chs_pkg::C_NEVER:     take = 1'b0;
      chs_pkg::C_ALWAYS:    take = 1'b1;
      chs_pkg::C_NO_INPUT:  take = !status_i.in_valid;
      chs_pkg::C_SKIP_PACK: take = status_i.skip_pack;
      chs_pkg::C_PACK_MORE: take = status_i.pack_more;
      chs_pkg::C_MOD_MORE:  take = status_i.mod_more;
      chs_pkg::C_SCAN_MORE: take = status_i.scan_more;
      chs_pkg::C_OUT_FREE:  take = status_i.out_free;
      default:              take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + 1'b1;
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= chs_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### hdl/chs_datapath.sv
// Datapath: key packing, bucket reduction, chain memory scan, insert and result register.
`timescale 1ns / 1ps

module chs_datapath #(
  parameter int BUCKETS     = 10,
  parameter int CHAIN_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chs_pkg::ctrl_t   ctrl_i,
  output chs_pkg::status_t status_o,
  chs_req_if.sink          req_i,
  chs_rsp_if.source        rsp_o
);

  localparam int BW      = $clog2(BUCKETS);
  localparam int RW      = BW + 8;
  localparam int FW      = $clog2(CHAIN_DEPTH + 1);
  localparam int IW      = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int ENTRIES = BUCKETS * CHAIN_DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KW      = chs_pkg::KEY_W;

  // One radix-256 step of key mod BUCKETS by restoring subtraction.
  function automatic logic [BW-1:0] reduce(input logic [BW-1:0] r, input logic [7:0] b);
    logic [RW-1:0] acc;
    acc = {r, b};
    for (int k = 7; k >= 0; k--) begin
      if (acc >= (RW'(BUCKETS) << k)) begin
        acc = acc - (RW'(BUCKETS) << k);
      end
    end
    return acc[BW-1:0];
  endfunction

  // Item registers.
  logic                         is_text_q, is_insert_q;
  logic [chs_pkg::LEN_W-1:0]    len_q;
  logic [chs_pkg::CHAR_W-1:0]   chars_q [4];
  logic [KW-1:0]                key_q;
  logic [chs_pkg::LEN_W-1:0]    cnt_q;
  logic [1:0]                   mcnt_q;
  logic [BW-1:0]                rem_q;

  // Scan registers.
  logic [AW-1:0]                base_q;
  logic [FW-1:0]                fill_cur_q;
  logic [FW-1:0]                idx_q;
  logic                         pend_q, found_q, stored_q, full_q;
  logic [KW:0]                  rd_q;

  // Chain fill counts and chain memory of {tag, key}.
  logic [FW-1:0]                fill_q [BUCKETS];
  logic [KW:0]                  mem [ENTRIES];

  // Result register.
  logic                         out_valid_q, out_found_q, out_stored_q, out_full_q;
  logic [KW-1:0]                out_key_q;

  logic                         do_load, hit, found_now, issue, wr_en, room, out_free;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic [chs_pkg::CHAR_W-1:0]   pack_char, mod_byte;
  logic [KW:0]                  key_pad;

  assign req_i.ready = ctrl_i.in_ready;
  assign do_load     = (ctrl_i.op == chs_pkg::OP_LOAD) && req_i.valid;

  // Character and byte selection for packing and reduction.
  assign pack_char = chars_q[cnt_q[1:0]];
  assign key_pad   = {1'b0, key_q};
  always_comb begin
    case (mcnt_q)
      2'd0:    mod_byte = key_pad[31:24];
      2'd1:    mod_byte = key_pad[23:16];
      2'd2:    mod_byte = key_pad[15:8];
      default: mod_byte = key_pad[7:0];
    endcase
  end

  // Scan compare of the previous read and issue of the next one.
  assign hit       = pend_q && (rd_q[KW-1:0] == key_q);
  assign found_now = found_q | hit;
  assign issue     = (ctrl_i.op == chs_pkg::OP_SCAN) && !found_now && (idx_q < fill_cur_q);
  assign rd_addr   = base_q + AW'(idx_q[IW-1:0]);
  assign wr_addr   = base_q + AW'(fill_cur_q[IW-1:0]);
  assign room      = fill_cur_q < FW'(CHAIN_DEPTH);
  assign wr_en     = (ctrl_i.op == chs_pkg::OP_INSERT) && is_insert_q && !found_q && room;
  assign out_free  = !out_valid_q || rsp_o.ready;

  // Flags for the sequencer.
  always_comb begin
    status_o.in_valid  = req_i.valid;
    status_o.skip_pack = !is_text_q || (len_q == '0);
    status_o.pack_more = (cnt_q + 1'b1) < len_q;
    status_o.mod_more  = mcnt_q != 2'd3;
    status_o.scan_more = issue;
    status_o.out_free  = out_free;
  end

  // Control state: fill counts, read pending flag and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) begin
        fill_q[b] <= '0;
      end
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_q[rem_q] <= fill_cur_q + 1'b1;
      end
      if (ctrl_i.op == chs_pkg::OP_SCAN_INIT) begin
        pend_q <= 1'b0;
      end else if (ctrl_i.op == chs_pkg::OP_SCAN) begin
        pend_q <= issue;
      end
      if ((ctrl_i.op == chs_pkg::OP_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item, packing, reduction and scan registers.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      is_text_q   <= req_i.kind[0];
      is_insert_q <= !req_i.kind[1];
      len_q       <= (req_i.text_length > chs_pkg::MAX_TEXT_LEN) ?
                     chs_pkg::MAX_TEXT_LEN : req_i.text_length;
      chars_q[0]  <= req_i.char_first;
      chars_q[1]  <= req_i.char_second;
      chars_q[2]  <= req_i.char_third;
      chars_q[3]  <= req_i.char_fourth;
      key_q       <= req_i.kind[0] ? '0 : req_i.number;
      cnt_q       <= '0;
      mcnt_q      <= '0;
      rem_q       <= '0;
    end
    if (ctrl_i.op == chs_pkg::OP_PACK) begin
      key_q <= (key_q * KW'(100)) + KW'(pack_char);
      cnt_q <= cnt_q + 1'b1;
    end
    if (ctrl_i.op == chs_pkg::OP_MOD) begin
      rem_q  <= reduce(rem_q, mod_byte);
      mcnt_q <= mcnt_q + 1'b1;
    end
    if (ctrl_i.op == chs_pkg::OP_SCAN_INIT) begin
      base_q     <= AW'(rem_q * CHAIN_DEPTH);
      fill_cur_q <= fill_q[rem_q];
      idx_q      <= '0;
      found_q    <= 1'b0;
      stored_q   <= 1'b0;
      full_q     <= 1'b0;
    end
    if (ctrl_i.op == chs_pkg::OP_SCAN) begin
      found_q <= found_now;
      if (issue) begin
        idx_q <= idx_q + 1'b1;
      end
    end
    if (ctrl_i.op == chs_pkg::OP_INSERT) begin
      stored_q <= wr_en;
      full_q   <= is_insert_q && !found_q && !room;
    end
    if ((ctrl_i.op == chs_pkg::OP_EMIT) && out_free) begin
      out_found_q  <= found_q;
      out_stored_q <= stored_q;
      out_full_q   <= full_q;
      out_key_q    <= key_q;
    end
  end

  // Chain memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {is_text_q, key_q};
    end
    if (issue) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found      = out_found_q;
  assign rsp_o.stored     = out_stored_q;
  assign rsp_o.chain_full = out_full_q;
  assign rsp_o.packed_key = out_key_q;

endmodule

### hdl/chained_hash_set.sv
// Top level of the chained hash set: microcode sequencer driving the datapath.
//
//   Channel  Direction  Handshake     Payload
//   req_i    in         valid/ready   kind, number, char_first..char_fourth, text_length
//   rsp_o    out        valid/ready   found, stored, chain_full, packed_key
//
// One transaction at a time. The time per item grows with L, the text length (0 for number
// keys, at most 4), and with S, the chain entries scanned (at most CHAIN_DEPTH,
// a hit ends the scan). The scan reads one chain memory entry per cycle through a
// single registered read port; the bucket is found in four byte steps of key mod BUCKETS.
// Reset clears the fill counts at once; no clearing pass is needed.
// A stalled response holds in the output register. The next request is still taken and
// runs up to its emit step and moves between emit and hold steps until the register frees.
`timescale 1ns / 1ps

module chained_hash_set #(
  parameter int BUCKETS     = 10,
  parameter int CHAIN_DEPTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  chs_req_if.sink  req_i,
  chs_rsp_if.source rsp_o
);

  chs_pkg::ctrl_t   ctrl;
  chs_pkg::status_t status;

  // Program sequencer.
  chs_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Datapath with chain memory.
  chs_datapath #(
    .BUCKETS     (BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .status_o (status),
    .req_i    (req_i),
    .rsp_o    (rsp_o)
  );

endmodule

### hdl/chs_checker.sv
// Port-level checker of the chained hash set and its bind statement.
`timescale 1ns / 1ps

module chs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      req_valid_i,
  input logic                      req_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      rsp_found_i,
  input logic                      rsp_stored_i,
  input logic                      rsp_full_i,
  input logic [chs_pkg::KEY_W-1:0] rsp_key_i
);

  // A stalled response keeps its contents.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_key_i)
      && $stable(rsp_found_i) && $stable(rsp_stored_i) && $stable(rsp_full_i))
    else $error("response changed while stalled");

  // A result reports at most one of found, stored and chain full.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> $countones({rsp_found_i, rsp_stored_i, rsp_full_i}) <= 1)
    else $error("conflicting result flags");

  // After a request transaction, requests stay blocked while the item is in progress.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i ##1 !req_ready_i ##1 !req_ready_i)
    else $error("request taken while an item is in progress");

  // A new result appears only while requests were blocked.
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(!req_ready_i))
    else $error("result issued while idle");

endmodule

bind chained_hash_set chs_checker u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_found_i  (rsp_o.found),
  .rsp_stored_i (rsp_o.stored),
  .rsp_full_i   (rsp_o.chain_full),
  .rsp_key_i    (rsp_o.packed_key)
);

### tb/sv/tb.sv
// Self-checking testbench for the chained hash set: random traffic, prediction and checks.
`timescale 1ns / 1ps

module tb;

  localparam int KIND_W        = chs_pkg::KIND_W;
  localparam int KEY_W         = chs_pkg::KEY_W;
  localparam int CHAR_W        = chs_pkg::CHAR_W;
  localparam int LEN_W         = chs_pkg::LEN_W;
  localparam int BUCKETS       = 10;
  localparam int CHAIN_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 850;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 60;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // One request transaction and the reply it should produce.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  number;
    logic [CHAR_W-1:0] char_first;
    logic [CHAR_W-1:0] char_second;
    logic [CHAR_W-1:0] char_third;
    logic [CHAR_W-1:0] char_fourth;
    logic [LEN_W-1:0]  text_length;
  } hash_request_t;

  typedef struct {
    logic             found;
    logic             stored;
    logic             chain_full;
    logic [KEY_W-1:0] packed_key;
  } set_reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  chs_req_if req ();
  chs_rsp_if rsp ();

  chained_hash_set #(
    .BUCKETS     (BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Mirror of the set contents. Tags are kept although no reply shows them.
  logic [KEY_W-1:0] chain_key [BUCKETS][CHAIN_DEPTH];
  logic             chain_tag [BUCKETS][CHAIN_DEPTH];
  int               chain_fill [BUCKETS];

  hash_request_t    request_backlog [$];
  set_reply_t       expected_replies [$];
  logic [KEY_W-1:0] number_pool [$];
  hash_request_t    text_pool [$];

  hash_request_t in_flight;
  int            total_requests;
  int            accepted_count = 0;
  int            mismatch_count = 0;
  int            cycle_count    = 0;
  int            gap_left       = 0;
  int            burst_left     = 0;
  int            stall_left     = 0;
  int            rsp_cycle      = 0;

  // Clock: 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Text packing: each character multiplies the key by 100 and adds its code, up to four characters.
  function automatic logic [KEY_W-1:0] pack_text(hash_request_t r);
    logic [CHAR_W-1:0] codes [4];
    logic [31:0]       acc;
    int                len;
    codes[0] = r.char_first;
    codes[1] = r.char_second;
    codes[2] = r.char_third;
    codes[3] = r.char_fourth;
    len = (r.text_length > chs_pkg::MAX_TEXT_LEN) ? int'(chs_pkg::MAX_TEXT_LEN) :
          int'(r.text_length);
    acc = '0;
    for (int i = 0; i < len; i++) begin
      acc = acc * 100 + codes[i];
    end
    return acc[KEY_W-1:0];
  endfunction

  // Applies one accepted request to the mirrored set and returns the reply it must cause.
  function automatic set_reply_t apply_to_set(hash_request_t r);
    set_reply_t       reply;
    logic [KEY_W-1:0] key;
    logic             is_text;
    logic             is_insert;
    int               bucket;
    is_text   = (r.kind == chs_pkg::KIND_INS_TEXT) || (r.kind == chs_pkg::KIND_SRC_TEXT);
    is_insert = (r.kind == chs_pkg::KIND_INS_NUM) || (r.kind == chs_pkg::KIND_INS_TEXT);
    key       = is_text ? pack_text(r) : r.number;
    bucket    = int'(key % BUCKETS);
    reply.found      = 1'b0;
    reply.stored     = 1'b0;
    reply.chain_full = 1'b0;
    reply.packed_key = key;
    // Lookups compare keys only; the type tag plays no part.
    for (int i = 0; i < chain_fill[bucket]; i++) begin
      if (chain_key[bucket][i] == key) reply.found = 1'b1;
    end
    if (is_insert && !reply.found) begin
      if (chain_fill[bucket] < CHAIN_DEPTH) begin
        chain_key[bucket][chain_fill[bucket]] = key;
        chain_tag[bucket][chain_fill[bucket]] = is_text;
        chain_fill[bucket]++;
        reply.stored = 1'b1;
      end else begin
        reply.chain_full = 1'b1;
      end
    end
    return reply;
  endfunction

  task automatic add_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] number,
                             input logic [CHAR_W-1:0] c1, input logic [CHAR_W-1:0] c2,
                             input logic [CHAR_W-1:0] c3, input logic [CHAR_W-1:0] c4,
                             input logic [LEN_W-1:0] len);
    hash_request_t r;
    r.kind        = kind;
    r.number      = number;
    r.char_first  = c1;
    r.char_second = c2;
    r.char_third  = c3;
    r.char_fourth = c4;
    r.text_length = len;
    request_backlog.push_back(r);
  endtask

  // Random traffic: many keys seen before so that hits, duplicates and full chains
  // are frequent, with fresh small, near-maximum and fully random keys mixed in.
  task automatic add_random_requests(input int count);
    hash_request_t r;
    int            roll;
    for (int n = 0; n < count; n++) begin
      r.kind        = KIND_W'($urandom_range(0, 3));
      r.number      = KEY_W'($urandom);
      r.char_first  = CHAR_W'($urandom);
      r.char_second = CHAR_W'($urandom);
      r.char_third  = CHAR_W'($urandom);
      r.char_fourth = CHAR_W'($urandom);
      r.text_length = LEN_W'($urandom_range(0, 7));
      roll = $urandom_range(0, 99);
      if (r.kind == chs_pkg::KIND_INS_NUM || r.kind == chs_pkg::KIND_SRC_NUM) begin
        if (roll < 40 && number_pool.size() > 0) begin
          r.number = number_pool[$urandom_range(0, number_pool.size() - 1)];
        end else if (roll < 55 && text_pool.size() > 0) begin
          // Same key as an earlier text item, looked up as a number.
          r.number = pack_text(text_pool[$urandom_range(0, text_pool.size() - 1)]);
        end else begin
          if (roll < 75) r.number = KEY_W'($urandom_range(0, 999));
          else if (roll < 85) r.number = KEY_MAX - KEY_W'($urandom_range(0, 99));
          number_pool.push_back(r.number);
          if (number_pool.size() > 64) void'(number_pool.pop_front());
        end
      end else begin
        if (roll < 45 && text_pool.size() > 0) begin
          hash_request_t prior;
          prior = text_pool[$urandom_range(0, text_pool.size() - 1)];
          r.char_first  = prior.char_first;
          r.char_second = prior.char_second;
          r.char_third  = prior.char_third;
          r.char_fourth = prior.char_fourth;
          r.text_length = (prior.text_length >= chs_pkg::MAX_TEXT_LEN) ?
                          LEN_W'($urandom_range(4, 7)) : prior.text_length;
        end else begin
          if (roll < 60) begin
            r.char_first  = CHAR_W'($urandom_range(0, 3));
            r.char_second = CHAR_W'($urandom_range(0, 3));
            r.char_third  = CHAR_W'($urandom_range(0, 3));
            r.char_fourth = CHAR_W'($urandom_range(0, 3));
          end
          text_pool.push_back(r);
          if (text_pool.size() > 64) void'(text_pool.pop_front());
        end
      end
      request_backlog.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  task automatic check_reply(input set_reply_t got);
    set_reply_t want;
    if (expected_replies.size() == 0) begin
      report_mismatch($sformatf("reply with no request outstanding, key %0d",
                                got.packed_key));
    end else begin
      want = expected_replies.pop_front();
      if (got.packed_key !== want.packed_key)
        report_mismatch($sformatf("packed_key %0d, expected %0d",
                                  got.packed_key, want.packed_key));
      if (got.found !== want.found)
        report_mismatch($sformatf("found %b, expected %b for key %0d",
                                  got.found, want.found, want.packed_key));
      if (got.stored !== want.stored)
        report_mismatch($sformatf("stored %b, expected %b for key %0d",
                                  got.stored, want.stored, want.packed_key));
      if (got.chain_full !== want.chain_full)
        report_mismatch($sformatf("chain_full %b, expected %b for key %0d",
                                  got.chain_full, want.chain_full, want.packed_key));
    end
  endtask

  task automatic park_request();
    req.valid       <= 1'b0;
    req.kind        <= chs_pkg::KIND_SRC_NUM;
    req.number      <= '0;
    req.char_first  <= '0;
    req.char_second <= '0;
    req.char_third  <= '0;
    req.char_fourth <= '0;
    req.text_length <= '0;
  endtask

  // Request driver: bursts of transactions separated by random gaps.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      park_request();
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (req.valid && req.ready) begin
        expected_replies.push_back(apply_to_set(in_flight));
        accepted_count++;
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 8);
          in_flight = request_backlog.pop_front();
          req.valid       <= 1'b1;
          req.kind        <= in_flight.kind;
          req.number      <= in_flight.number;
          req.char_first  <= in_flight.char_first;
          req.char_second <= in_flight.char_second;
          req.char_third  <= in_flight.char_third;
          req.char_fourth <= in_flight.char_fourth;
          req.text_length <= in_flight.text_length;
          burst_left--;
          // Some stretches run back to back; otherwise gaps land on any phase of a lookup.
          if (burst_left == 0) begin
            if ((accepted_count % 300) < 60 || $urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 40);
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Reply monitor: checks every transaction; stalls come in phases of the run.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp.ready <= 1'b0;
      stall_left = 0;
      rsp_cycle  = 0;
    end else begin
      set_reply_t got;
      rsp_cycle++;
      if (rsp.valid && rsp.ready) begin
        got.found      = rsp.found;
        got.stored     = rsp.stored;
        got.chain_full = rsp.chain_full;
        got.packed_key = rsp.packed_key;
        check_reply(got);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if ((rsp_cycle % 1500) >= 500 && $urandom_range(0, 3) == 0)
          stall_left = $urandom_range(1, 25);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("chained_hash_set regression: fail");
      $finish;
    end
  end

  initial begin
    for (int b = 0; b < BUCKETS; b++) chain_fill[b] = 0;

    // Directed part: key extremes, text packing corners, duplicates across key types.
    add_request(chs_pkg::KIND_SRC_NUM,  '0,      8'hff, 8'hff, 8'hff, 8'hff, 3'd7);
    add_request(chs_pkg::KIND_INS_NUM,  '0,      8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    add_request(chs_pkg::KIND_INS_NUM,  '0,      8'h12, 8'h34, 8'h56, 8'h78, 3'd3);
    add_request(chs_pkg::KIND_INS_NUM,  KEY_MAX, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    add_request(chs_pkg::KIND_SRC_NUM,  KEY_MAX, 8'h00, 8'h00, 8'h00, 8'h00, 3'd4);
    add_request(chs_pkg::KIND_SRC_NUM,  KEY_MAX - 31'd10, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    add_request(chs_pkg::KIND_INS_TEXT, KEY_MAX, 8'hff, 8'hff, 8'hff, 8'hff, 3'd0);
    add_request(chs_pkg::KIND_SRC_TEXT, '0,      8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    add_request(chs_pkg::KIND_INS_TEXT, KEY_MAX, 8'd65, 8'd66, 8'hff, 8'hff, 3'd2);
    add_request(chs_pkg::KIND_SRC_NUM,  31'd6566, 8'hff, 8'hff, 8'hff, 8'hff, 3'd7);
    add_request(chs_pkg::KIND_INS_TEXT, '0,      8'hff, 8'hff, 8'hff, 8'hff, 3'd4);
    add_request(chs_pkg::KIND_INS_TEXT, KEY_MAX, 8'hff, 8'hff, 8'hff, 8'hff, 3'd7);
    add_request(chs_pkg::KIND_SRC_TEXT, '0,      8'hff, 8'hff, 8'hff, 8'hff, 3'd5);
    add_request(chs_pkg::KIND_INS_TEXT, '0,      8'h00, 8'h00, 8'h07, 8'hff, 3'd3);
    add_request(chs_pkg::KIND_SRC_NUM,  31'd7,   8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    add_request(chs_pkg::KIND_INS_TEXT, '0,      8'h00, 8'hff, 8'hff, 8'hff, 3'd1);
    add_request(chs_pkg::KIND_INS_TEXT, '0,      8'h01, 8'h00, 8'h00, 8'h00, 3'd4);
    add_request(chs_pkg::KIND_SRC_TEXT, KEY_MAX, 8'h00, 8'h00, 8'hff, 8'hff, 3'd2);
    add_request(chs_pkg::KIND_INS_NUM,  31'd1,   8'hff, 8'hff, 8'hff, 8'hff, 3'd7);
    add_request(chs_pkg::KIND_SRC_NUM,  31'd11,  8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    add_request(chs_pkg::KIND_INS_TEXT, '0,      8'h00, 8'h01, 8'h00, 8'h00, 3'd2);
    add_request(chs_pkg::KIND_SRC_TEXT, 31'h5555, 8'h7a, 8'h7a, 8'h7a, 8'h7a, 3'd6);
    add_request(chs_pkg::KIND_INS_NUM,  31'h2aaaaaaa, 8'h55, 8'haa, 8'h55, 8'haa, 3'd5);
    add_random_requests(RANDOM_ITEMS);
    total_requests = request_backlog.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to go in and every reply to come out, then watch for strays.
    while (accepted_count < total_requests) @(posedge clk);
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("chained_hash_set regression: pass");
    end else begin
      $display("chained_hash_set regression: fail");
    end
    $finish;
  end

endmodule
